### src/typed_named_value_deframer_macros.svh
// Assertion macros shared by the typed named-value deframer RTL.
`ifndef TYPED_NAMED_VALUE_DEFRAMER_MACROS_SVH
`define TYPED_NAMED_VALUE_DEFRAMER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TNVD_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tnvd check failed");

// A condition that must hold in the cycle after a trigger.
`define TNVD_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("tnvd check failed");

`endif

### src/tnvd_pkg.sv
// Package with the types and codes of the typed named-value deframer.
`default_nettype none

package tnvd_pkg;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_TYPE  = 3'd3,
        PH_VAL   = 3'd4,
        PH_NAME  = 3'd5
    } phase_t;

    typedef logic [2:0] status_t;
    typedef logic [1:0] kind_t;
    typedef logic [2:0] reg_index_t;

    localparam status_t ST_NAME_BYTE = 3'd0;
    localparam status_t ST_DONE      = 3'd1;
    localparam status_t ST_BAD_SYNC  = 3'd2;
    localparam status_t ST_BAD_TYPE  = 3'd3;
    localparam status_t ST_TOO_LONG  = 3'd4;
    localparam status_t ST_ZERO_LEN  = 3'd5;

    localparam kind_t KIND_SIGNED16  = 2'd0;
    localparam kind_t KIND_UNSIGNED8 = 2'd1;
    localparam kind_t KIND_FLAG      = 2'd2;

    localparam reg_index_t REG_SYNC_FIRST      = 3'd0;
    localparam reg_index_t REG_SYNC_SECOND     = 3'd1;
    localparam reg_index_t REG_CODE_SIGNED16   = 3'd2;
    localparam reg_index_t REG_CODE_UNSIGNED8  = 3'd3;
    localparam reg_index_t REG_CODE_FLAG       = 3'd4;
    localparam reg_index_t REG_MAX_NAME_LENGTH = 3'd5;

    localparam logic [7:0] RST_SYNC_FIRST      = 8'd170;
    localparam logic [7:0] RST_SYNC_SECOND     = 8'd85;
    localparam logic [7:0] RST_CODE_SIGNED16   = 8'd105;
    localparam logic [7:0] RST_CODE_UNSIGNED8  = 8'd117;
    localparam logic [7:0] RST_CODE_FLAG       = 8'd98;
    localparam logic [7:0] RST_MAX_NAME_LENGTH = 8'd16;

endpackage

`default_nettype wire

### src/typed_named_value_deframer.sv
// Typed named-value deframer: turns a received byte stream into name and value results.
//
// Input channel: in_valid/in_ready carry one received byte (rx_byte) per transaction.
// Output channel: out_valid/out_ready carry at most one result per input byte:
// a name byte with its index, a frame-done result with type, value and name length,
// or an error status (bad sync, bad type, name too long, zero length).
// Bytes that produce no result (accepted sync, length and type bytes, and value bytes
// except the last one of a frame without a name) are absorbed silently.
// An accepted byte is held in an input register, decoded by one level of logic that
// also updates the frame state, and the result lands in the output register.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the input
// register holds one more byte; in_ready drops only when both are occupied.
// Reset clears the frame state to waiting for the first sync byte, empties both
// registers and loads the configuration registers with their default codes.
// Configuration is written over the APB port; the user must write it only while no
// transaction is in flight, as the block itself does not enforce this.
`default_nettype none
`include "typed_named_value_deframer_macros.svh"

module typed_named_value_deframer
    import tnvd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  status,
    output logic      [1:0]  value_type,
    output logic signed [15:0] value,
    output logic             has_name_byte,
    output logic      [7:0]  name_byte,
    output logic      [7:0]  name_index,
    output logic      [7:0]  name_length
);

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [7:0] code_signed16_reg;
    logic [7:0] code_unsigned8_reg;
    logic [7:0] code_flag_reg;
    logic [7:0] max_name_length_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_advance;

    phase_t     phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    kind_t      kind_reg, kind_next;
    logic [15:0] value_bytes_reg, value_bytes_next;
    logic       value_count_reg, value_count_next;
    logic [7:0] name_count_reg, name_count_next;
    logic [7:0] exp_len_reg, exp_len_next;

    logic       type_known;
    kind_t      type_kind;
    logic [8:0] type_rem;
    logic [8:0] name_count_inc;
    logic [15:0] dec_value;

    logic       res_valid;
    status_t    res_status;
    kind_t      res_type;
    logic [15:0] res_value;
    logic       res_has;
    logic [7:0] res_byte;
    logic [7:0] res_index;
    logic [7:0] res_length;

    logic       out_valid_reg;
    status_t    out_status_reg;
    kind_t      out_type_reg;
    logic [15:0] out_value_reg;
    logic       out_has_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_index_reg;
    logic [7:0] out_length_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg      <= RST_SYNC_FIRST;
            sync_second_reg     <= RST_SYNC_SECOND;
            code_signed16_reg   <= RST_CODE_SIGNED16;
            code_unsigned8_reg  <= RST_CODE_UNSIGNED8;
            code_flag_reg       <= RST_CODE_FLAG;
            max_name_length_reg <= RST_MAX_NAME_LENGTH;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SYNC_FIRST:      sync_first_reg      <= pwdata[7:0];
                REG_SYNC_SECOND:     sync_second_reg     <= pwdata[7:0];
                REG_CODE_SIGNED16:   code_signed16_reg   <= pwdata[7:0];
                REG_CODE_UNSIGNED8:  code_unsigned8_reg  <= pwdata[7:0];
                REG_CODE_FLAG:       code_flag_reg       <= pwdata[7:0];
                REG_MAX_NAME_LENGTH: max_name_length_reg <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SYNC_FIRST:      prdata = {24'd0, sync_first_reg};
            REG_SYNC_SECOND:     prdata = {24'd0, sync_second_reg};
            REG_CODE_SIGNED16:   prdata = {24'd0, code_signed16_reg};
            REG_CODE_UNSIGNED8:  prdata = {24'd0, code_unsigned8_reg};
            REG_CODE_FLAG:       prdata = {24'd0, code_flag_reg};
            REG_MAX_NAME_LENGTH: prdata = {24'd0, max_name_length_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Input register and handshake.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // Type decode; the signed code wins over unsigned, which wins over flag.
    always_comb
    begin
        type_known = 1'b1;
        type_kind  = KIND_FLAG;
        if (s1_byte_reg == code_signed16_reg)
        begin
            type_kind = KIND_SIGNED16;
        end
        else if (s1_byte_reg == code_unsigned8_reg)
        begin
            type_kind = KIND_UNSIGNED8;
        end
        else if (s1_byte_reg != code_flag_reg)
        begin
            type_known = 1'b0;
        end
        type_rem = {1'b0, frame_length_reg}
                 - ((type_kind == KIND_SIGNED16) ? 9'd3 : 9'd2);
    end

    assign name_count_inc = {1'b0, name_count_reg} + 9'd1;

    always_comb
    begin
        case (kind_reg)
            KIND_SIGNED16:  dec_value = value_bytes_reg;
            KIND_UNSIGNED8: dec_value = {8'd0, value_bytes_reg[7:0]};
            default:        dec_value = {15'd0, (value_bytes_reg[7:0] != 8'd0)};
        endcase
    end

    // Frame state machine, one byte per pass.
    always_comb
    begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        kind_next         = kind_reg;
        value_bytes_next  = value_bytes_reg;
        value_count_next  = value_count_reg;
        name_count_next   = name_count_reg;
        exp_len_next      = exp_len_reg;
        res_valid         = 1'b0;
        res_status        = ST_NAME_BYTE;
        res_type          = KIND_SIGNED16;
        res_value         = 16'd0;
        res_has           = 1'b0;
        res_byte          = 8'd0;
        res_index         = 8'd0;
        res_length        = 8'd0;

        if (s1_advance)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (s1_byte_reg == sync_first_reg)
                    begin
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD_SYNC;
                    end
                end
                PH_SYNC2:
                begin
                    if (s1_byte_reg == sync_second_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD_SYNC;
                        phase_next = PH_SYNC1;
                    end
                end
                PH_LEN:
                begin
                    if (s1_byte_reg == 8'd0)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_ZERO_LEN;
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        frame_length_next = s1_byte_reg;
                        phase_next        = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (!type_known)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_BAD_TYPE;
                        phase_next = PH_SYNC1;
                    end
                    else if (type_rem[8] || (type_rem[7:0] > max_name_length_reg))
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TOO_LONG;
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        kind_next        = type_kind;
                        exp_len_next     = type_rem[7:0];
                        value_bytes_next = 16'd0;
                        value_count_next = 1'b0;
                        name_count_next  = 8'd0;
                        phase_next       = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (!value_count_reg)
                    begin
                        value_bytes_next[7:0] = s1_byte_reg;
                    end
                    else
                    begin
                        value_bytes_next[15:8] = s1_byte_reg;
                    end
                    value_count_next = 1'b1;
                    if (value_count_reg || (kind_reg != KIND_SIGNED16))
                    begin
                        if (exp_len_reg == 8'd0)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_DONE;
                            res_type   = kind_reg;
                            case (kind_reg)
                                KIND_SIGNED16:  res_value = value_bytes_next;
                                KIND_UNSIGNED8: res_value = {8'd0, value_bytes_next[7:0]};
                                default:        res_value =
                                    {15'd0, (value_bytes_next[7:0] != 8'd0)};
                            endcase
                            phase_next = PH_SYNC1;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    name_count_next = name_count_inc[7:0];
                    res_valid       = 1'b1;
                    res_type        = kind_reg;
                    res_has         = 1'b1;
                    res_byte        = s1_byte_reg;
                    res_index       = name_count_reg;
                    if (name_count_inc >= {1'b0, exp_len_reg})
                    begin
                        res_status = ST_DONE;
                        res_value  = dec_value;
                        res_length = exp_len_reg;
                        phase_next = PH_SYNC1;
                    end
                    else
                    begin
                        res_status = ST_NAME_BYTE;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            frame_length_reg <= 8'd0;
            kind_reg         <= KIND_SIGNED16;
            value_bytes_reg  <= 16'd0;
            value_count_reg  <= 1'b0;
            name_count_reg   <= 8'd0;
            exp_len_reg      <= 8'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            kind_reg         <= kind_next;
            value_bytes_reg  <= value_bytes_next;
            value_count_reg  <= value_count_next;
            name_count_reg   <= name_count_next;
            exp_len_reg      <= exp_len_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && res_valid)
        begin
            out_status_reg <= res_status;
            out_type_reg   <= res_type;
            out_value_reg  <= res_value;
            out_has_reg    <= res_has;
            out_byte_reg   <= res_byte;
            out_index_reg  <= res_index;
            out_length_reg <= res_length;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign value_type    = out_type_reg;
    assign value         = out_value_reg;
    assign has_name_byte = out_has_reg;
    assign name_byte     = out_byte_reg;
    assign name_index    = out_index_reg;
    assign name_length   = out_length_reg;

    `TNVD_ASSERT_ALWAYS(a_name_count_in_range,
        (phase_reg != PH_NAME) || (name_count_reg < exp_len_reg))
    `TNVD_ASSERT_NEXT(a_error_resyncs,
        s1_advance && res_valid && (res_status != ST_NAME_BYTE) && (res_status != ST_DONE),
        phase_reg == PH_SYNC1)
    `TNVD_ASSERT_ALWAYS(a_name_flag_matches_status,
        !out_valid_reg || !out_has_reg ||
        (out_status_reg == ST_NAME_BYTE) || (out_status_reg == ST_DONE))
    `TNVD_ASSERT_ALWAYS(a_stall_needs_full_pipe,
        in_ready || (s1_valid_reg && out_valid_reg && !out_ready))

endmodule

`default_nettype wire
